>>> design/kseq_pkg.sv
// ----------------------------------------------------------------------------
// kseq_pkg
// Shared types, op codes and modifier helpers of the keyboard event queue.
// ----------------------------------------------------------------------------
package kseq_pkg;

  // Item op codes
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam int unsigned QueueDepthDefault = 32;
  localparam int unsigned CmdFifoDepth      = 4;
  localparam int unsigned KeyCount          = 128;
  localparam int unsigned KeyW              = 7;

  // Modifier keys sit at 0x60..0x67: upper key bits select the group
  localparam logic [3:0] ModKeyGroup = 4'hC;

  // Ring entry: key, release flag, compact modifiers
  localparam int unsigned ModW   = 4;
  localparam int unsigned EntryW = KeyW + 1 + ModW;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  typedef struct packed {
    logic [1:0]      op;
    logic [KeyW-1:0] key;   // decoded key (key op) or queried key (query op)
    logic            up;    // release flag of a key op
    logic            hi;    // queried key is 128 or above
  } kseq_cmd_t;

  // Compact modifiers: [0] command, [1] shift, [2] option, [3] control
  function automatic logic [ModW-1:0] mod_compact(input logic [7:0] held);
    mod_compact = {held[3], held[4] | held[5], held[0] | held[1], held[6] | held[7]};
  endfunction

  function automatic logic [15:0] mod_word(input logic [ModW-1:0] m);
    mod_word = {3'b000, m[3], m[2], 1'b0, m[1], m[0], 8'h00};
  endfunction

endpackage

>>> design/keyboard_scancode_event_queue_unit.sv
// Path: command queue, pending stage, then output register. Throughput: one item
// per cycle while the output is taken; the back issues one command a cycle from
// the command queue, limited by the single write port of each memory.
// Reset: key map reads as all released, ring empty, modifiers clear; the
// ring contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// keyboard_scancode_event_queue_unit
// Keyboard event block: decodes serial scan bytes, tracks held keys and
// modifiers, and queues press/release events for later popping.
// ----------------------------------------------------------------------------
module keyboard_scancode_event_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = kseq_pkg::QueueDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] op, [9:2] serial_byte, [17:10] query_key, [23:18] zero
  input  logic [kseq_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] event_valid, [7:1] event_key, [8] event_down, [24:9] event_modifiers,
  // [25] key_is_down, [41:26] current_modifiers, [42] queue_dropped,
  // [47:43] zero
  output logic [kseq_pkg::OutDataW-1:0]   m_axis_tdata
);

  // Front to queue
  kseq_pkg::kseq_cmd_t fr_cmd;
  logic                fr_push;
  logic                q_full;

  // Queue to back
  kseq_pkg::kseq_cmd_t bk_cmd;
  logic                bk_valid;
  logic                bk_pop;

  // Decode and classify each item as it is accepted
  kseq_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .cmd_push_o      (fr_push),
    .cmd_o           (fr_cmd),
    .cmd_full_i      (q_full)
  );

  // Hold decoded commands so the front keeps taking items while the
  // result side stalls
  kseq_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .cmd_i   (fr_cmd),
    .full_o  (q_full),
    .pop_i   (bk_pop),
    .valid_o (bk_valid),
    .cmd_o   (bk_cmd)
  );

  // Update the key map and ring, then register the result item
  kseq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (bk_valid),
    .cmd_i           (bk_cmd),
    .cmd_pop_o       (bk_pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

>>> design/kseq_front.sv
// ----------------------------------------------------------------------------
// kseq_front
// Accepts items and decodes serial bytes into key commands for the queue.
// ----------------------------------------------------------------------------
module kseq_front (
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [1:0] op, [9:2] serial_byte, [17:10] query_key, [23:18] zero
  input  logic [kseq_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                            cmd_push_o,
  output kseq_pkg::kseq_cmd_t             cmd_o,
  input  logic                            cmd_full_i
);

  logic [1:0] op;
  logic [7:0] sbyte;
  logic [7:0] qkey;
  logic [7:0] code;
  logic [7:0] rot;

  assign op    = s_axis_tdata_i[1:0];
  assign sbyte = s_axis_tdata_i[9:2];
  assign qkey  = s_axis_tdata_i[17:10];

  // invert, then rotate right by one
  assign code = ~sbyte;
  assign rot  = {code[0], code[7:1]};

  always_comb begin
    cmd_o.op  = op;
    cmd_o.up  = rot[7];
    cmd_o.hi  = qkey[7];
    if (op == kseq_pkg::OP_KEY) begin
      cmd_o.key = rot[6:0];
    end else begin
      cmd_o.key = qkey[6:0];
    end
  end

  assign s_axis_tready_o = ~cmd_full_i;
  assign cmd_push_o      = s_axis_tvalid_i & ~cmd_full_i;

endmodule

>>> design/kseq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// kseq_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module kseq_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  kseq_pkg::kseq_cmd_t  cmd_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output kseq_pkg::kseq_cmd_t  cmd_o
);

  localparam int unsigned Depth = kseq_pkg::CmdFifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  kseq_pkg::kseq_cmd_t slot_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rp_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wp_d  = do_push ? wp_q + 1'b1 : wp_q;
    rp_d  = do_pop  ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

endmodule

>>> design/kseq_back.sv
// ----------------------------------------------------------------------------
// kseq_back
// Executes commands: key map, modifier state, event ring, result register.
// ----------------------------------------------------------------------------
module kseq_back #(
  parameter int unsigned QUEUE_DEPTH = kseq_pkg::QueueDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  kseq_pkg::kseq_cmd_t             cmd_i,
  output logic                            cmd_pop_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [kseq_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  localparam int unsigned PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned KeyW   = kseq_pkg::KeyW;
  localparam int unsigned ModW   = kseq_pkg::ModW;
  localparam int unsigned EntryW = kseq_pkg::EntryW;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  // Memories
  logic [EntryW-1:0] ring_mem [QUEUE_DEPTH];
  logic              map_mem  [kseq_pkg::KeyCount];
  logic [kseq_pkg::KeyCount-1:0] map_vld_q;

  // Control state
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp_nxt, rp_nxt;
  logic [7:0]      mod_q, mod_d;

  // Pending stage
  logic            pend_q;
  logic            pend_evt_q, pend_drop_q, pend_qry_q;
  logic [ModW-1:0] pend_cmod_q;
  logic [EntryW-1:0] ring_rd_q;
  logic            map_rd_q;

  // Output register
  logic            out_vld_q;
  logic [kseq_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic issue, out_load, pend_adv;
  logic is_key, is_pop, is_qry;
  logic full, empty, do_push, do_pop;
  logic [ModW-1:0] cmod_nxt;

  assign out_load  = pend_q & (~out_vld_q | m_axis_tready_i);
  assign pend_adv  = out_load;
  assign issue     = cmd_valid_i & (~pend_q | pend_adv);
  assign cmd_pop_o = issue;

  assign is_key = (cmd_i.op == kseq_pkg::OP_KEY);
  assign is_pop = (cmd_i.op == kseq_pkg::OP_POP);
  assign is_qry = (cmd_i.op == kseq_pkg::OP_QUERY);

  assign wp_nxt  = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
  assign rp_nxt  = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
  assign full    = (wp_nxt == rp_q);
  assign empty   = (wp_q == rp_q);
  assign do_push = issue & is_key & ~full;
  assign do_pop  = issue & is_pop & ~empty;

  // Modifier keys shadowed in flops so the word is ready every cycle
  always_comb begin
    mod_d = mod_q;
    if (issue && is_key && cmd_i.key[KeyW-1:3] == kseq_pkg::ModKeyGroup) begin
      mod_d[cmd_i.key[2:0]] = ~cmd_i.up;
    end
  end
  assign cmod_nxt = kseq_pkg::mod_compact(mod_d);

  assign wp_d = do_push ? wp_nxt : wp_q;
  assign rp_d = do_pop  ? rp_nxt : rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      mod_q     <= '0;
      map_vld_q <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      mod_q <= mod_d;
      if (issue && is_key) begin
        map_vld_q[cmd_i.key] <= 1'b1;
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (pend_adv) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Key map memory: write on key ops, registered read on issue
  always_ff @(posedge clk_i) begin
    if (issue && is_key) begin
      map_mem[cmd_i.key] <= ~cmd_i.up;
    end
    if (issue) begin
      map_rd_q <= map_mem[cmd_i.key] & map_vld_q[cmd_i.key];
    end
  end

  // Event ring memory
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ring_mem[wp_q] <= {cmod_nxt, cmd_i.up, cmd_i.key};
    end
    if (do_pop) begin
      ring_rd_q <= ring_mem[rp_q];
    end
  end

  // Pending payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_evt_q  <= is_pop & ~empty;
      pend_drop_q <= is_key & full;
      pend_qry_q  <= is_qry & ~cmd_i.hi;
      pend_cmod_q <= cmod_nxt;
    end
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = pend_evt_q;
    out_data_d[7:1]   = pend_evt_q ? ring_rd_q[KeyW-1:0] : '0;
    out_data_d[8]     = pend_evt_q & ~ring_rd_q[KeyW];
    out_data_d[24:9]  = pend_evt_q ? kseq_pkg::mod_word(ring_rd_q[EntryW-1:KeyW+1]) : '0;
    out_data_d[25]    = pend_qry_q & map_rd_q;
    out_data_d[41:26] = kseq_pkg::mod_word(pend_cmod_q);
    out_data_d[42]    = pend_drop_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
